[hw/rtl/opdl_pkg.sv]
// Package for the offset-point drive linearizer: beat types, constants, CORDIC table.
// No dependencies.
package opdl_pkg;

  localparam int CordicStepsDef = 16;
  localparam int FracBitsDef    = 8;
  localparam int TabLen         = 24;
  localparam int LimitW         = 15;
  localparam logic [LimitW-1:0] LimitReset = 15'd256;

  localparam logic [1:0] CmdPose   = 2'd0;
  localparam logic [1:0] CmdTarget = 2'd1;
  localparam logic [1:0] CmdDone   = 2'd2;
  localparam logic [1:0] CmdTwist  = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic               stop_request;
    logic signed [15:0] twist_x;
    logic signed [15:0] twist_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               singular;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_ctl_t;

  function automatic logic [22:0] atan_tab(input logic [4:0] i);
    logic [22:0] r;
    case (i)
      5'd0: r = 23'd2097152;  5'd1: r = 23'd1238021; 5'd2: r = 23'd654136;
      5'd3: r = 23'd332051;   5'd4: r = 23'd166669;  5'd5: r = 23'd83416;
      5'd6: r = 23'd41718;    5'd7: r = 23'd20860;   5'd8: r = 23'd10430;
      5'd9: r = 23'd5215;     5'd10: r = 23'd2608;   5'd11: r = 23'd1304;
      5'd12: r = 23'd652;     5'd13: r = 23'd326;    5'd14: r = 23'd163;
      5'd15: r = 23'd81;      5'd16: r = 23'd41;     5'd17: r = 23'd20;
      5'd18: r = 23'd10;      5'd19: r = 23'd5;      5'd20: r = 23'd3;
      5'd21: r = 23'd1;       5'd22: r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/offset_point_drive_linearizer_unit.sv]
// Top level of the offset-point drive linearizer: sequencer, state, arithmetic.
// Depends on opdl_pkg, opdl_cordic, opdl_divider.
//
//  channel | direction | handshake     | beat
//  in      | input     | valid / stall | in_beat_t
//  out     | output    | valid / stall | out_beat_t
//  cfg     | input     | valid / ready | velocity_limit, 15 bits
//
// in_stall_o stays high after an accepted beat until the sequencer is idle again:
//   pose: eight products on one multiplier, then CORDIC vectoring, which is skipped
//   when the quaternion is zero or in gimbal lock;
//   twist: CORDIC rotation, eight products and the two bit-serial divisions, skipped
//   when stopped or the offset x is zero; target and done do not stall.
// A result waits in the output register under out_stall_i; reset clears state, limit 1.0.
module offset_point_drive_linearizer_unit import opdl_pkg::*; #(
  parameter int CordicSteps = CordicStepsDef,
  parameter int FracBits    = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_beat_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_beat_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LimitW-1:0]  cfg_data_i
);
  localparam logic [3:0] SIdle = 4'd0, SMul = 4'd1, SPoseChk = 4'd2, SVecW = 4'd3,
                         STw = 4'd4, SRotW = 4'd5, SRot = 4'd6, SDivV = 4'd7,
                         SDivVW = 4'd8, SDivW = 4'd9, SDivWW = 4'd10, SOut = 4'd11;

  logic [3:0] st_q, st_d;
  logic [2:0] k_q, k_d;
  in_beat_t in_q;
  logic [LimitW-1:0] lim_q;
  logic signed [15:0] head_q, head_d, offx_q, offy_q;
  logic stop_q;
  logic signed [35:0] acc_q [4];
  logic signed [35:0] acc_d [4];
  logic signed [17:0] cs_q, sn_q;
  logic signed [48:0] nv_q, nv_d;
  logic signed [15:0] v_q, w_q;
  logic out_valid_q;
  out_beat_t out_q;
  logic neg_q;

  // shared multiplier: one product per cycle
  logic signed [33:0] ma;
  logic signed [15:0] mb;
  logic signed [49:0] mp;
  assign mp = ma * mb;

  cordic_ctl_t cctl;
  logic signed [35:0] cx_i, cy_i, cx_o, cy_o;
  logic signed [25:0] cz_i, cz_o;
  logic cdone;
  logic dstart, ddone;
  logic signed [48:0] dnum;
  logic signed [31:0] dden;
  logic signed [49:0] dquo;

  opdl_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i, .rst_ni, .ctl_i(cctl), .x_i(cx_i), .y_i(cy_i), .z_i(cz_i),
    .done_o(cdone), .x_o(cx_o), .y_o(cy_o), .z_o(cz_o)
  );

  opdl_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  function automatic logic signed [15:0] clamp16(input logic signed [49:0] v,
                                                 input logic [LimitW-1:0] l);
    logic signed [15:0] r;
    if (v > $signed({35'd0, l})) r = $signed({1'b0, l});
    else if (v < -50'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

  logic signed [35:0] d_sum, n10, n00, n20, a20;
  logic signed [35:0] vx0, vy0;
  logic signed [25:0] zr, zr2, zadj;
  logic rneg;
  logic signed [25:0] zout;
  logic signed [35:0] cq, sq;

  always_comb begin
    d_sum = acc_q[0];
    n10 = acc_q[1];
    n00 = acc_q[0] - acc_q[2];
    n20 = acc_q[3];
    a20 = n20[35] ? -n20 : n20;
    vx0 = n00; vy0 = n10; zr = '0;
    if (n00[35]) begin
      if (!n10[35]) begin vx0 = n10; vy0 = -n00; zr = 26'sd4194304; end
      else begin vx0 = -n10; vy0 = n00; zr = -26'sd4194304; end
    end
    zr2 = $signed({{2{head_q[15]}}, head_q, 8'd0});
    rneg = 1'b0; zadj = zr2;
    if (zr2 > 26'sd4194304) begin zadj = zr2 - 26'sd8388608; rneg = 1'b1; end
    else if (zr2 < -26'sd4194304) begin zadj = zr2 + 26'sd8388608; rneg = 1'b1; end
    zout = (cz_o + 26'sd128) >>> 8;
    cq = ((neg_q ? -cx_o : cx_o) + 36'sd8192) >>> 14;
    sq = ((neg_q ? -cy_o : cy_o) + 36'sd8192) >>> 14;
  end

  // multiplier operand schedule by step counter
  always_comb begin
    ma = '0; mb = '0;
    if (st_q == SMul) begin
      case (k_q)
        3'd0: begin ma = 34'(in_q.quat_x); mb = in_q.quat_x; end
        3'd1: begin ma = 34'(in_q.quat_y); mb = in_q.quat_y; end
        3'd2: begin ma = 34'(in_q.quat_z); mb = in_q.quat_z; end
        3'd3: begin ma = 34'(in_q.quat_w); mb = in_q.quat_w; end
        3'd4: begin ma = 34'(in_q.quat_x); mb = in_q.quat_y; end
        3'd5: begin ma = 34'(in_q.quat_w); mb = in_q.quat_z; end
        3'd6: begin ma = 34'(in_q.quat_x); mb = in_q.quat_z; end
        default: begin ma = 34'(in_q.quat_w); mb = in_q.quat_y; end
      endcase
    end else if (st_q == SRot) begin
      case (k_q)
        3'd0: begin ma = 34'(cs_q); mb = offx_q; end
        3'd1: begin ma = 34'(sn_q); mb = offy_q; end
        3'd2: begin ma = 34'(sn_q); mb = offx_q; end
        3'd3: begin ma = 34'(cs_q); mb = offy_q; end
        3'd4: begin ma = acc_q[0][33:0]; mb = in_q.twist_x; end
        3'd5: begin ma = acc_q[1][33:0]; mb = in_q.twist_y; end
        3'd6: begin ma = 34'(cs_q); mb = in_q.twist_y; end
        default: begin ma = 34'(sn_q); mb = in_q.twist_x; end
      endcase
    end
  end

  logic in_acc, out_acc, out_load;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign out_load = (st_q == SOut) && (!out_valid_q || out_acc);
  assign in_stall_o = (st_q != SIdle);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    st_d = st_q; k_d = k_q;
    acc_d = acc_q;
    nv_d = nv_q;
    head_d = head_q;
    cctl = '0; cx_i = vx0; cy_i = vy0; cz_i = zr;
    dstart = 1'b0; dnum = nv_q; dden = $signed({offx_q, 16'd0});
    unique case (st_q)
      SIdle: begin
        if (in_acc) begin
          k_d = '0;
          unique case (in_data_i.cmd)
            CmdPose: begin
              st_d = SMul;
              for (int j = 0; j < 4; j++) acc_d[j] = '0;
            end
            CmdTwist: st_d = STw;
            default: st_d = SIdle;
          endcase
        end
      end
      SMul: begin
        k_d = k_q + 3'd1;
        case (k_q) inside
          3'd0, 3'd3: acc_d[0] = acc_q[0] + mp[35:0];
          3'd1, 3'd2: begin
            acc_d[0] = acc_q[0] + mp[35:0];
            acc_d[2] = acc_q[2] + {mp[34:0], 1'b0};
          end
          3'd4, 3'd5: acc_d[1] = acc_q[1] + {mp[34:0], 1'b0};
          3'd6: acc_d[3] = acc_q[3] + {mp[34:0], 1'b0};
          default: begin acc_d[3] = acc_q[3] - {mp[34:0], 1'b0}; st_d = SPoseChk; end
        endcase
      end
      SPoseChk: begin
        if (d_sum == 36'sd0 || a20 >= d_sum) begin
          head_d = '0;
          st_d = SIdle;
        end else begin
          cctl.start = 1'b1; cctl.vec_mode = 1'b1;
          st_d = SVecW;
        end
      end
      SVecW: begin
        if (cdone) begin
          head_d = zout[15:0];
          st_d = SIdle;
        end
      end
      STw: begin
        if (stop_q || offx_q == 16'sd0) begin
          st_d = SOut;
        end else begin
          cctl.start = 1'b1; cctl.vec_mode = 1'b0;
          cx_i = 36'sd652032874; cy_i = '0; cz_i = zadj;
          st_d = SRotW;
        end
      end
      SRotW: begin
        if (cdone) begin
          st_d = SRot;
          k_d = '0;
        end
      end
      SRot: begin
        k_d = k_q + 3'd1;
        case (k_q)
          3'd0: acc_d[0] = mp[35:0];
          3'd1: acc_d[0] = acc_q[0] - mp[35:0];
          3'd2: acc_d[1] = mp[35:0];
          3'd3: acc_d[1] = acc_q[1] + mp[35:0];
          3'd4: nv_d = mp[48:0];
          3'd5: nv_d = nv_q + mp[48:0];
          3'd6: acc_d[2] = mp[35:0];
          default: begin acc_d[2] = acc_q[2] - mp[35:0]; st_d = SDivV; end
        endcase
      end
      SDivV: begin
        dstart = 1'b1; dnum = nv_q; st_d = SDivVW;
      end
      SDivVW: begin
        if (ddone) st_d = SDivW;
      end
      SDivW: begin
        dstart = 1'b1; dnum = 49'(acc_q[2]) <<< FracBits; st_d = SDivWW;
      end
      SDivWW: begin
        if (ddone) st_d = SOut;
      end
      SOut: begin
        if (!out_valid_q || out_acc) st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      k_q <= '0;
      lim_q <= LimitReset;
      head_q <= '0;
      offx_q <= '0;
      offy_q <= '0;
      stop_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      k_q <= k_d;
      head_q <= head_d;
      if (cfg_valid_i && cfg_ready_o) lim_q <= cfg_data_i;
      if (in_acc && in_data_i.cmd == CmdTarget) begin
        offx_q <= in_data_i.target_x;
        offy_q <= in_data_i.target_y;
      end
      if (in_acc && in_data_i.cmd == CmdDone) stop_q <= in_data_i.stop_request;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_data_i;
    acc_q <= acc_d;
    nv_q <= nv_d;
    if (st_q == STw) neg_q <= rneg;
    if (st_q == SRotW && cdone) begin
      cs_q <= cq[17:0];
      sn_q <= sq[17:0];
    end
    if (st_q == SDivVW && ddone) v_q <= clamp16(dquo, lim_q);
    if (st_q == SDivWW && ddone) w_q <= clamp16(dquo, lim_q);
    if (out_load) begin
      out_q.singular <= !stop_q && offx_q == 16'sd0;
      if (stop_q || offx_q == 16'sd0) begin
        out_q.linear_cmd <= '0;
        out_q.angular_cmd <= '0;
      end else begin
        out_q.linear_cmd <= v_q;
        out_q.angular_cmd <= w_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef SYNTH
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> in_stall_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped under stall");
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.singular) |->
    (out_data_o.linear_cmd == 16'sd0 && out_data_o.angular_cmd == 16'sd0))
    else $error("singular result not zero");
`endif
endmodule

[hw/rtl/opdl_cordic.sv]
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on opdl_pkg.
module opdl_cordic import opdl_pkg::*; #(
  parameter int CordicSteps = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cordic_ctl_t        ctl_i,
  input  logic signed [35:0] x_i,
  input  logic signed [35:0] y_i,
  input  logic signed [25:0] z_i,
  output logic               done_o,
  output logic signed [35:0] x_o,
  output logic signed [35:0] y_o,
  output logic signed [25:0] z_o
);
  localparam int Steps = (CordicSteps < TabLen) ? CordicSteps : TabLen;

  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [25:0] z_q, z_d;
  logic [4:0] i_q, i_d;
  logic busy_q, busy_d, vec_q, vec_d, done_q, done_d;
  logic signed [35:0] dx, dy;
  logic signed [25:0] at;
  logic up;

  always_comb begin
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    at = $signed({3'b000, atan_tab(i_q)});
    up = vec_q ? !y_q[35] : !z_q[25];
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    busy_d = busy_q; vec_d = vec_q; done_d = 1'b0;
    if (ctl_i.start) begin
      x_d = x_i; y_d = y_i; z_d = z_i; i_d = '0;
      vec_d = ctl_i.vec_mode; busy_d = 1'b1;
    end else if (busy_q) begin
      if (vec_q == up) begin
        x_d = x_q + (vec_q ? dx : -dx);
      end else begin
        x_d = x_q + (vec_q ? -dx : dx);
      end
      if (vec_q) begin
        y_d = up ? y_q - dy : y_q + dy;
        z_d = up ? z_q + at : z_q - at;
      end else begin
        x_d = up ? x_q - dx : x_q + dx;
        y_d = up ? y_q + dy : y_q - dy;
        z_d = up ? z_q - at : z_q + at;
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      vec_q  <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      vec_q  <= vec_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

[hw/rtl/opdl_divider.sv]
// Bit-serial restoring divider, one quotient bit per cycle, round half away.
// Depends on opdl_pkg.
module opdl_divider import opdl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [48:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [49:0] quo_o
);
  logic [48:0] n_q, n_d;
  logic [31:0] r_q, r_d;
  logic [31:0] d_q, d_d;
  logic [48:0] qb_q, qb_d;
  logic [5:0]  k_q, k_d;
  logic busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [32:0] trial;
  logic [49:0] mag;
  logic [49:0] rem2;

  always_comb begin
    n_d = n_q; r_d = r_q; d_d = d_q; qb_d = qb_q; k_d = k_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    trial = {r_q, n_q[48]};
    if (start_i) begin
      n_d = num_i[48] ? 49'(-num_i) : num_i;
      d_d = den_i[31] ? 32'(-den_i) : den_i;
      neg_d = num_i[48] ^ den_i[31];
      r_d = '0; qb_d = '0; k_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[47:0], 1'b0};
      if (trial >= {1'b0, d_q}) begin
        r_d = 32'(trial - {1'b0, d_q});
        qb_d = {qb_q[47:0], 1'b1};
      end else begin
        r_d = trial[31:0];
        qb_d = {qb_q[47:0], 1'b0};
      end
      k_d = k_q + 6'd1;
      if (k_q == 6'd48) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; r_q <= r_d; d_q <= d_d; qb_q <= qb_d; neg_q <= neg_d;
  end

  // round: add one when 2r >= d
  assign rem2 = {17'd0, r_q, 1'b0};
  assign mag = {1'b0, qb_q} + ((rem2 >= {18'd0, d_q}) ? 50'd1 : 50'd0);
  assign quo_o = neg_q ? -$signed(mag) : $signed(mag);
  assign done_o = done_q;
endmodule
